FILE: rtl/crc8_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// CRC-8 frame receiver assertion macros
// Shared concurrent checks, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRC8_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define CRC8FR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8 frame receiver check failed");

// next-cycle implication
`define CRC8FR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8 frame receiver check failed");

`endif

FILE: rtl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, constants and the byte-wide CRC-8 step of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W    = 8;
    localparam int WIN_LEN   = 6;
    localparam int SHORT_LEN = 3;
    localparam int KIND_W    = 3;
    localparam int KIND_COUNT = 7;
    localparam int SLOT_W    = 4;
    localparam int RETRY_W   = 4;
    localparam int PAYLOAD_W = 32;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CORRECT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRONG   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ROW     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COLUMN  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FIRST = 3'd1;

    localparam logic [BYTE_W-1:0] CFG_RESET [CFG_COUNT] = '{
        8'h07, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07
    };

    typedef struct packed {
        logic take;        // request accepted this cycle
        logic crc_start;
        logic crc_step;
        logic emit;        // load output register
        logic emit_fault;
        logic emit_ok;
    } dp_cmd_t;

    typedef struct packed {
        logic fault;       // last request was a fault header
        logic fail;        // retries exhausted
        logic check;       // window needs a CRC check
        logic crc_last;
        logic crc_match;
        logic out_free;
    } dp_sts_t;

    // eight MSB-first shifts of one byte
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc_in ^ data;
        for (int j = 0; j < BYTE_W; j++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crc8fr_ctrl.sv
// ----------------------------------------------------------------------------
// crc8fr_ctrl
// Sequencer: take request, evaluate, CRC over window, compare, load result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  crc8fr_pkg::dp_sts_t sts,
    output crc8fr_pkg::dp_cmd_t cmd
);
    import crc8fr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CRC,
        S_CMP,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   fault_reg;
    logic   ok_reg;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
            end
            S_EVAL:
            begin
                cmd.crc_start = sts.check && !sts.fault && !sts.fail;
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit       = sts.out_free;
                cmd.emit_fault = fault_reg;
                cmd.emit_ok    = ok_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fault_reg <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (sts.fault)
                    begin
                        fault_reg <= 1'b1;
                        ok_reg    <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else if (sts.fail)
                    begin
                        fault_reg <= 1'b0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else if (sts.check)
                        state_reg <= S_CRC;
                    else
                        state_reg <= S_IDLE;
                end
                S_CRC:
                begin
                    if (sts.crc_last)
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (sts.crc_match)
                    begin
                        fault_reg <= 1'b0;
                        ok_reg    <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc8fr_datapath.sv
// ----------------------------------------------------------------------------
// crc8fr_datapath
// Config registers, frame window, counters, byte-wide CRC and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc8_frame_receiver_assert.svh"

module crc8fr_datapath #(
    parameter int SLOT_COUNT        = 16,
    parameter int SHORT_RETRY_LIMIT = 8,
    parameter int LONG_RETRY_LIMIT  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [crc8fr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crc8fr_pkg::BYTE_W-1:0]        cfg_data,
    input  logic [crc8fr_pkg::BYTE_W-1:0]        rx_byte,
    input  crc8fr_pkg::dp_cmd_t                  cmd,
    output crc8fr_pkg::dp_sts_t                  sts,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [crc8fr_pkg::KIND_W-1:0]        frame_kind,
    output logic [crc8fr_pkg::PAYLOAD_W-1:0]     payload,
    output logic                                 crc_ok,
    output logic [crc8fr_pkg::SLOT_W-1:0]        slot_index,
    output logic                                 matrix_done
);
    import crc8fr_pkg::*;

    logic [BYTE_W-1:0]    cfg_reg [CFG_COUNT];

    logic                 hunting_reg, hunting_next;
    logic [2:0]           fill_reg, fill_next;
    logic                 long_reg, long_next;
    logic [RETRY_W-1:0]   retry_reg, retry_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [SLOT_W-1:0]    row_reg, row_next;
    logic [SLOT_W-1:0]    col_reg, col_next;
    logic                 fault_reg, fault_next;
    logic                 fail_reg, fail_next;
    logic                 check_reg, check_next;
    logic [BYTE_W-1:0]    win_reg [WIN_LEN];
    logic [BYTE_W-1:0]    win_next [WIN_LEN];
    logic [BYTE_W-1:0]    crc_reg, crc_next;
    logic [2:0]           ptr_reg, ptr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 ok_reg, ok_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 done_reg, done_next;

    logic                 code_hit;
    logic [KIND_W-1:0]    code_kind;
    logic [2:0]           len_last;
    logic [RETRY_W-1:0]   retry_sat;
    logic [RETRY_W-1:0]   retry_limit;
    logic                 row_wrap;
    logic                 col_wrap;

    // first matching header code wins
    always_comb
    begin
        code_hit  = 1'b0;
        code_kind = KIND_FINISH;
        for (int k = KIND_COUNT - 1; k >= 0; k--)
        begin
            if (cfg_reg[k + 1] == rx_byte)
            begin
                code_hit  = 1'b1;
                code_kind = KIND_W'(k);
            end
        end
    end

    assign len_last    = long_reg ? 3'(WIN_LEN - 1) : 3'(SHORT_LEN - 1);
    assign retry_sat   = (retry_reg == '1) ? retry_reg : retry_reg + 1'b1;
    assign retry_limit = long_reg ? RETRY_W'(LONG_RETRY_LIMIT) : RETRY_W'(SHORT_RETRY_LIMIT);
    assign row_wrap    = ({1'b0, row_reg} >= (SLOT_W + 1)'(SLOT_COUNT - 1));
    assign col_wrap    = ({1'b0, col_reg} >= (SLOT_W + 1)'(SLOT_COUNT - 1));

    always_comb
    begin
        hunting_next   = hunting_reg;
        fill_next      = fill_reg;
        long_next      = long_reg;
        retry_next     = retry_reg;
        kind_next      = kind_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        fault_next     = fault_reg;
        fail_next      = fail_reg;
        check_next     = check_reg;
        win_next       = win_reg;
        crc_next       = crc_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        payload_next   = payload_reg;
        ok_next        = ok_reg;
        slot_next      = slot_reg;
        done_next      = done_reg;

        if (cmd.take)
        begin
            fault_next = 1'b0;
            fail_next  = 1'b0;
            check_next = 1'b0;
            if (hunting_reg)
            begin
                if (code_hit && code_kind == KIND_FAULT)
                    fault_next = 1'b1;
                else if (code_hit)
                begin
                    win_next[0]  = rx_byte;
                    fill_next    = 3'd1;
                    long_next    = (code_kind >= KIND_ROW);
                    kind_next    = code_kind;
                    retry_next   = '0;
                    hunting_next = 1'b0;
                end
            end
            else if (fill_reg <= len_last)
            begin
                win_next[fill_reg] = rx_byte;
                fill_next          = fill_reg + 3'd1;
                check_next         = (fill_reg == len_last);
            end
            else
            begin
                // slide window by one byte
                for (int i = 0; i < WIN_LEN - 1; i++)
                begin
                    if (3'(i) < len_last)
                        win_next[i] = win_reg[i + 1];
                end
                win_next[len_last] = rx_byte;
                retry_next         = retry_sat;
                fail_next          = (retry_sat >= retry_limit);
                check_next         = (retry_sat < retry_limit);
            end
        end

        if (cmd.crc_start)
        begin
            crc_next = '0;
            ptr_next = 3'd0;
        end
        else if (cmd.crc_step)
        begin
            crc_next = crc8_byte(crc_reg, win_reg[ptr_reg], cfg_reg[REG_CRC_POLY]);
            ptr_next = (ptr_reg == 3'd0) ? 3'd2 : ptr_reg + 3'd1;  // skip CRC byte
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (cmd.emit_fault)
            begin
                out_kind_next = KIND_FAULT;
                payload_next  = '0;
                ok_next       = 1'b0;
                slot_next     = '0;
                done_next     = 1'b0;
            end
            else
            begin
                out_kind_next = kind_reg;
                if (long_reg)
                    payload_next = {win_reg[5], win_reg[4], win_reg[3], win_reg[2]};
                else
                    payload_next = {(PAYLOAD_W - BYTE_W)'(0), win_reg[2]};
                ok_next   = cmd.emit_ok;
                slot_next = '0;
                done_next = 1'b0;
                if (kind_reg == KIND_ROW)
                begin
                    slot_next = row_reg;
                    row_next  = row_wrap ? '0 : row_reg + 1'b1;
                end
                else if (kind_reg == KIND_COLUMN)
                begin
                    slot_next = col_reg;
                    done_next = col_wrap;
                    col_next  = col_wrap ? '0 : col_reg + 1'b1;
                end
                hunting_next = 1'b1;
                fill_next    = 3'd0;
                retry_next   = '0;
            end
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < CFG_COUNT; r++)
                cfg_reg[r] <= CFG_RESET[r];
            hunting_reg   <= 1'b1;
            fill_reg      <= 3'd0;
            long_reg      <= 1'b0;
            retry_reg     <= '0;
            kind_reg      <= KIND_FINISH;
            row_reg       <= '0;
            col_reg       <= '0;
            fault_reg     <= 1'b0;
            fail_reg      <= 1'b0;
            check_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg[cfg_index] <= cfg_data;
            hunting_reg   <= hunting_next;
            fill_reg      <= fill_next;
            long_reg      <= long_next;
            retry_reg     <= retry_next;
            kind_reg      <= kind_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            fault_reg     <= fault_next;
            fail_reg      <= fail_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        crc_reg      <= crc_next;
        ptr_reg      <= ptr_next;
        out_kind_reg <= out_kind_next;
        payload_reg  <= payload_next;
        ok_reg       <= ok_next;
        slot_reg     <= slot_next;
        done_reg     <= done_next;
    end

    assign sts.fault     = fault_reg;
    assign sts.fail      = fail_reg;
    assign sts.check     = check_reg;
    assign sts.crc_last  = (ptr_reg == len_last);
    assign sts.crc_match = (crc_reg == win_reg[1]);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign frame_kind  = out_kind_reg;
    assign payload     = payload_reg;
    assign crc_ok      = ok_reg;
    assign slot_index  = slot_reg;
    assign matrix_done = done_reg;

    `CRC8FR_ASSERT_IMPLIES(a_emit_slot_free, cmd.emit, !(out_valid_reg && out_stall))
    `CRC8FR_ASSERT_IMPLIES(a_frame_has_header, cmd.take && !hunting_reg, fill_reg != 3'd0)
    `CRC8FR_ASSERT_NEXT(a_finish_rehunts, cmd.emit && !cmd.emit_fault, hunting_reg)
    `CRC8FR_ASSERT_IMPLIES(a_crc_inside_frame, cmd.crc_step, !hunting_reg && !cmd.take)

endmodule

`default_nettype wire

FILE: rtl/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// Header-hunting deframer for 3-byte and 6-byte frames with CRC-8 check.
// ----------------------------------------------------------------------------
// Bytes enter one request at a time on rx_byte. While hunting, bytes that
// match no header code are dropped; a fault header is reported at once.
// A short header opens a 3-byte frame and a data header a 6-byte frame,
// laid out header, CRC, data. The CRC-8 (MSB first, zero start, polynomial
// from crc_poly) runs over header and data bytes. On a mismatch each new
// byte slides the window by one until the CRC matches or the retry limit
// ends the frame with crc_ok low. Each request is taken and evaluated; it
// then returns to idle when it needs no check and reports nothing, loads
// a result when it reports a fault header or a run-out retry count, and
// when a check is due runs one CRC step per covered byte, compares, and
// loads the result on a match. The CRC unit handles one byte per cycle.
// A finished result sits in an output register, so the next request is
// taken while it waits; a later result waits only if that register is still
// stalled. Config registers are to be written by the user through cfg_we/
// cfg_index/cfg_data only while the block is idle; it is not enforced.
`default_nettype none

module crc8_frame_receiver #(
    parameter int SLOT_COUNT        = 16,
    parameter int SHORT_RETRY_LIMIT = 8,
    parameter int LONG_RETRY_LIMIT  = 8
) (
    input  logic         clk,
    input  logic         rst_n,

    // config write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data,

    // byte input
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   rx_byte,

    // frame results
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   frame_kind,
    output logic [31:0]  payload,
    output logic         crc_ok,
    output logic [3:0]   slot_index,
    output logic         matrix_done
);
    import crc8fr_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    crc8fr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window, counters, CRC unit, output register
    crc8fr_datapath #(
        .SLOT_COUNT        (SLOT_COUNT),
        .SHORT_RETRY_LIMIT (SHORT_RETRY_LIMIT),
        .LONG_RETRY_LIMIT  (LONG_RETRY_LIMIT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .frame_kind  (frame_kind),
        .payload     (payload),
        .crc_ok      (crc_ok),
        .slot_index  (slot_index),
        .matrix_done (matrix_done)
    );

endmodule

`default_nettype wire
